// ----- design/dcfc_pkg.sv -----
// Package for the drive command frame checker: frame and result types,
// ASCII codes, digit helpers. No dependencies.

package dcfc_pkg;

  // ASCII codes used in a frame
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_ONE   = 8'd49;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_END   = 8'd69;  // 'E'
  localparam logic [7:0] CHAR_FWD   = 8'd70;  // 'F'
  localparam logic [7:0] CHAR_BACK  = 8'd66;  // 'B'
  localparam logic [7:0] CHAR_RIGHT = 8'd82;  // 'R'
  localparam logic [7:0] CHAR_LEFT  = 8'd76;  // 'L'

  localparam logic [7:0] SPEED_LIMIT = 8'd100;

  localparam int IN_WIDTH  = 64;
  localparam int OUT_WIDTH = 32;

  // one input frame, byte 0 in the lowest bits of tdata
  typedef struct packed {
    logic [7:0] end_marker;
    logic [7:0] steer_letter;
    logic [7:0] angle_units;
    logic [7:0] angle_tens;
    logic [7:0] drive_letter;
    logic [7:0] speed_units;
    logic [7:0] speed_tens;
    logic [7:0] speed_hundreds;
  } frame_t;

  // decoded frame handed from the parser to the store
  typedef struct packed {
    logic       well_formed;
    logic [7:0] speed;
    logic       reverse;
    logic [6:0] angle;
    logic       left;
  } parse_t;

  // one result word, accepted in the lowest bit
  typedef struct packed {
    logic [6:0] pad;
    logic [7:0] signed_angle;
    logic       steer_left;
    logic [6:0] steer_angle;
    logic       reverse;
    logic [6:0] speed_percent;
    logic       accepted;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // low nibble of an ASCII digit is its value
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    return c[3:0];
  endfunction

endpackage

// ----- design/dcfc_parse.sv -----
// Frame parser: checks every byte position and forms speed and angle.
// Depends on dcfc_pkg.

module dcfc_parse
  import dcfc_pkg::*;
(
  input  frame_t frame,
  output parse_t parsed
);

  logic [7:0] hund_term;
  logic [7:0] tens_term;
  logic [6:0] angle_tens_term;

  // position checks, then digit values to binary; values only meaningful when well formed
  always_comb begin
    parsed.well_formed = (frame.end_marker == CHAR_END)
      && ((frame.speed_hundreds == CHAR_ZERO) || (frame.speed_hundreds == CHAR_ONE))
      && is_digit(frame.speed_tens) && is_digit(frame.speed_units)
      && ((frame.drive_letter == CHAR_FWD) || (frame.drive_letter == CHAR_BACK))
      && is_digit(frame.angle_tens) && is_digit(frame.angle_units)
      && ((frame.steer_letter == CHAR_RIGHT) || (frame.steer_letter == CHAR_LEFT));
    hund_term       = frame.speed_hundreds[0] ? 8'd100 : 8'd0;
    tens_term       = {4'd0, digit_val(frame.speed_tens)} * 8'd10;
    angle_tens_term = {3'd0, digit_val(frame.angle_tens)} * 7'd10;
    parsed.speed    = hund_term + tens_term + {4'd0, digit_val(frame.speed_units)};
    parsed.angle    = angle_tens_term + {3'd0, digit_val(frame.angle_units)};
    parsed.reverse  = (frame.drive_letter == CHAR_BACK);
    parsed.left     = (frame.steer_letter == CHAR_LEFT);
  end

endmodule

// ----- design/dcfc_store.sv -----
// Drive command store and result register.
// Depends on dcfc_pkg.

module dcfc_store
  import dcfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  parse_t  parsed,
  output result_t result
);

  logic [6:0] stored_speed, stored_speed_next;
  logic       stored_reverse, stored_reverse_next;
  logic [6:0] stored_angle, stored_angle_next;
  logic       stored_left, stored_left_next;
  logic       accept_next;

  // next store contents for the frame in the input register
  always_comb begin
    stored_speed_next   = stored_speed;
    stored_reverse_next = stored_reverse;
    stored_angle_next   = stored_angle;
    stored_left_next    = stored_left;
    accept_next         = 1'b0;
    if (parsed.well_formed) begin
      if (parsed.speed > SPEED_LIMIT) begin
        stored_speed_next = 7'd0;
      end else begin
        stored_speed_next   = parsed.speed[6:0];
        stored_reverse_next = parsed.reverse;
        stored_angle_next   = parsed.angle;
        stored_left_next    = parsed.left;
        accept_next         = 1'b1;
      end
    end
  end

  // store state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_speed   <= 7'd0;
      stored_reverse <= 1'b0;
      stored_angle   <= 7'd0;
      stored_left    <= 1'b0;
    end else if (advance) begin
      stored_speed   <= stored_speed_next;
      stored_reverse <= stored_reverse_next;
      stored_angle   <= stored_angle_next;
      stored_left    <= stored_left_next;
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (advance) begin
      result.pad           <= '0;
      result.accepted      <= accept_next;
      result.speed_percent <= stored_speed_next;
      result.reverse       <= stored_reverse_next;
      result.steer_angle   <= stored_angle_next;
      result.steer_left    <= stored_left_next;
      result.signed_angle  <= stored_left_next ? 8'(-{1'b0, stored_angle_next})
                                               : {1'b0, stored_angle_next};
    end
  end

endmodule

// ----- design/drive_command_frame_checker_top.sv -----
// Drive command frame checker top level: input register, parser, store.
// Depends on dcfc_pkg, dcfc_parse, dcfc_store.
//
//   channel  | dir | word
//   s_axis   | in  | one 8-byte command frame
//   m_axis   | out | one result per frame
//
// One frame per cycle sustained while m_tready does not stall; a frame's result
// passes the input register, then the result register, before it can be taken.
// Reset clears the stored command to zero speed, forward, zero angle, right.
// A stall on m_tready holds the result register; the input register keeps
// taking a frame while it is empty or moving on in the same cycle.

module drive_command_frame_checker_top
  import dcfc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // speed_hundreds, speed_tens, speed_units, drive_letter, angle_tens,
  // angle_units, steer_letter, end_marker; 8 bits each from bit 0 up
  input  logic [IN_WIDTH-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // accepted, speed_percent[7], reverse, steer_angle[7], steer_left,
  // signed_angle[8], zero fill to 32 bits; from bit 0 up
  output logic [OUT_WIDTH-1:0] m_tdata
);

  frame_t  frame;
  logic    frame_valid;
  logic    advance;
  parse_t  parsed;
  result_t result;

  // handshake: frame moves on when the result register is free
  assign advance  = frame_valid && (!m_tvalid || m_tready);
  assign s_tready = !frame_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (s_tready) begin
      frame_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      frame <= frame_t'(s_tdata);
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  dcfc_parse u_parse (
    .frame  (frame),
    .parsed (parsed)
  );

  dcfc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .parsed  (parsed),
    .result  (result)
  );

  assign m_tdata = result;

endmodule

// ----- bench/tb_drive_command_frame_checker_top.sv -----
// Testbench for drive_command_frame_checker_top: streams command frames in,
// predicts each result word from its own copy of the stored command and
// checks every field. Depends on dcfc_pkg and the RTL of the top level.

module tb_drive_command_frame_checker_top;
  import dcfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // speed_hundreds, speed_tens, speed_units, drive_letter, angle_tens,
  // angle_units, steer_letter, end_marker; 8 bits each from bit 0 up
  logic [IN_WIDTH-1:0]  s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // accepted, speed_percent[7], reverse, steer_angle[7], steer_left,
  // signed_angle[8], zero fill to 32 bits; from bit 0 up
  logic [OUT_WIDTH-1:0] m_tdata;

  // stored command as the bench expects it
  logic [6:0] cmd_speed = '0;
  logic       cmd_reverse = 1'b0;
  logic [6:0] cmd_angle = '0;
  logic       cmd_left = 1'b0;

  result_t expected_results[$];
  int      fail_count = 0;
  int      cycle_count = 0;

  // idling controls, owned by the test tasks
  bit tx_gap_en = 1'b0;
  bit rx_stall_en = 1'b0;
  int hold_requests = 0;

  drive_command_frame_checker_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycle_count,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly zero, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver side: random stalls plus a long hold-off on request
  int stall_left = 0;
  int holds_done = 0;
  always @(posedge clk) begin
    if (hold_requests != holds_done) begin
      holds_done = hold_requests;
      stall_left = HOLD_CYCLES;
    end else if (stall_left == 0 && rx_stall_en) begin
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic digit_ok(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // next stored command and the result word it gives
  function automatic result_t predict_drive_result(input frame_t f);
    result_t r;
    logic    well_formed;
    int      speed;
    well_formed = (f.end_marker == CHAR_END)
      && (f.speed_hundreds == CHAR_ZERO || f.speed_hundreds == CHAR_ONE)
      && digit_ok(f.speed_tens) && digit_ok(f.speed_units)
      && (f.drive_letter == CHAR_FWD || f.drive_letter == CHAR_BACK)
      && digit_ok(f.angle_tens) && digit_ok(f.angle_units)
      && (f.steer_letter == CHAR_RIGHT || f.steer_letter == CHAR_LEFT);
    r = '0;
    if (well_formed) begin
      speed = (int'(f.speed_hundreds) - 48) * 100 + (int'(f.speed_tens) - 48) * 10
            + (int'(f.speed_units) - 48);
      if (speed > int'(SPEED_LIMIT)) begin
        cmd_speed = '0;
      end else begin
        cmd_speed   = speed[6:0];
        cmd_reverse = (f.drive_letter == CHAR_BACK);
        cmd_angle   = 7'((int'(f.angle_tens) - 48) * 10 + (int'(f.angle_units) - 48));
        cmd_left    = (f.steer_letter == CHAR_LEFT);
        r.accepted  = 1'b1;
      end
    end
    r.speed_percent = cmd_speed;
    r.reverse       = cmd_reverse;
    r.steer_angle   = cmd_angle;
    r.steer_left    = cmd_left;
    r.signed_angle  = cmd_left ? 8'(-int'(cmd_angle)) : {1'b0, cmd_angle};
    return r;
  endfunction

  // eight characters, byte 0 first
  function automatic frame_t text_frame(input string s);
    frame_t f;
    f.speed_hundreds = s[0];
    f.speed_tens     = s[1];
    f.speed_units    = s[2];
    f.drive_letter   = s[3];
    f.angle_tens     = s[4];
    f.angle_units    = s[5];
    f.steer_letter   = s[6];
    f.end_marker     = s[7];
    return f;
  endfunction

  // well-formed frame with random content, speed up to 199
  function automatic frame_t random_good_frame();
    frame_t f;
    f.speed_hundreds = ($urandom_range(0, 99) < 60) ? CHAR_ZERO : CHAR_ONE;
    f.speed_tens     = CHAR_ZERO + 8'($urandom_range(0, 9));
    f.speed_units    = CHAR_ZERO + 8'($urandom_range(0, 9));
    f.drive_letter   = $urandom_range(0, 1) ? CHAR_BACK : CHAR_FWD;
    f.angle_tens     = CHAR_ZERO + 8'($urandom_range(0, 9));
    f.angle_units    = CHAR_ZERO + 8'($urandom_range(0, 9));
    f.steer_letter   = $urandom_range(0, 1) ? CHAR_LEFT : CHAR_RIGHT;
    f.end_marker     = CHAR_END;
    return f;
  endfunction

  // raw noise, or a good frame with one byte replaced
  function automatic frame_t random_bad_frame();
    logic [IN_WIDTH-1:0] bits;
    int                  pos;
    if ($urandom_range(0, 1)) begin
      bits = {$urandom(), $urandom()};
    end else begin
      bits = random_good_frame();
      pos = $urandom_range(0, 7);
      bits[pos*8 +: 8] = 8'($urandom_range(0, 255));
    end
    return frame_t'(bits);
  endfunction

  // offer one word, wait for the handshake, then predict
  task automatic send_frame(input frame_t f);
    int gap;
    gap = tx_gap_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= f;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_drive_result(f));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata);
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with none pending", m_tdata));
      end else begin
        want = expected_results.pop_front();
        if (got.accepted != want.accepted)
          report_mismatch($sformatf("accepted %0d want %0d", got.accepted, want.accepted));
        if (got.speed_percent != want.speed_percent)
          report_mismatch($sformatf("speed_percent %0d want %0d",
                                    got.speed_percent, want.speed_percent));
        if (got.reverse != want.reverse)
          report_mismatch($sformatf("reverse %0d want %0d", got.reverse, want.reverse));
        if (got.steer_angle != want.steer_angle)
          report_mismatch($sformatf("steer_angle %0d want %0d",
                                    got.steer_angle, want.steer_angle));
        if (got.steer_left != want.steer_left)
          report_mismatch($sformatf("steer_left %0d want %0d",
                                    got.steer_left, want.steer_left));
        if (got.signed_angle != want.signed_angle)
          report_mismatch($sformatf("signed_angle %0d want %0d",
                                    $signed(got.signed_angle), $signed(want.signed_angle)));
      end
    end
  end

  // limits, every letter, each position broken in turn
  task automatic test_directed_frames();
    string frames[$];
    frames = '{"200F10RE", "050F25RE", "100B99LE", "101F10RE", "199B00LE",
               "000F00RE", "/00F00RE", "0:0F00RE", "00/F00RE", "050X10RE",
               "050f10RE", "050F:0RE", "050F1/RE", "050F10XE", "050F10Rx",
               "099B50LE", "099F09RE", "1/9F10RE", "100F00LE"};
    tx_gap_en   = 1'b0;
    rx_stall_en = 1'b0;
    foreach (frames[i]) send_frame(text_frame(frames[i]));
    send_frame('0);
    send_frame('1);
    wait_drained();
  endtask

  // mostly good frames, some noise, idling switched per chunk
  task automatic test_random_frames(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_gap_en   = ($urandom_range(0, 3) != 0);
        rx_stall_en = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < 75) send_frame(random_good_frame());
      else send_frame(random_bad_frame());
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_output_holdoff();
    tx_gap_en   = 1'b0;
    rx_stall_en = 1'b0;
    hold_requests++;
    for (int i = 0; i < 40; i++) send_frame(random_good_frame());
    wait_drained();
  endtask

  // sender pauses until every result is back, then carries on
  task automatic test_drain_pause();
    tx_gap_en   = 1'b1;
    rx_stall_en = 1'b1;
    for (int i = 0; i < 20; i++) send_frame(random_good_frame());
    wait_drained();
    for (int i = 0; i < 20; i++) begin
      if ($urandom_range(0, 3) == 0) send_frame(random_bad_frame());
      else send_frame(random_good_frame());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_random_frames(700);
    test_output_holdoff();
    test_drain_pause();
    wait_drained();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/dcfc_pkg.sv
design/dcfc_parse.sv
design/dcfc_store.sv
design/drive_command_frame_checker_top.sv
bench/tb_drive_command_frame_checker_top.sv
